### hdl/ihpo_pkg.sv
// Shared types, constants and helpers for the identifier hash port offset block.
package ihpo_pkg;

  localparam int unsigned DEFAULT_MAX_ID_LEN = 64;
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  localparam logic [9:0] PORT_MOD = 10'd999;
  localparam int unsigned MOD_SHIFT = 42;
  localparam logic [32:0] MOD_RECIP = 33'((64'd1 << MOD_SHIFT) / 64'(PORT_MOD));
  localparam int unsigned QUOT_W = 65 - MOD_SHIFT;
  localparam int unsigned REM_W = 11;

  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

  typedef struct packed {
    logic [7:0] id_byte;
    logic       is_end;
    logic       bad;
  } ihpo_item_t;

  typedef struct packed {
    logic [31:0] hash;
    logic        ok;
  } ihpo_res_t;

  function automatic logic char_allowed(input logic [7:0] c);
    logic ok;
    ok = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
         (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
         (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
         c == CHAR_DASH || c == CHAR_UNDERSCORE || c == CHAR_DOT;
    return ok;
  endfunction

endpackage

### hdl/id_hash_port_offset.sv
// Top level of the identifier hash port offset block.
//
// Input channel: in_valid_i / in_stall_o with id_byte_i and is_end_i. Each
// transfer with is_end_i low adds one character; a transfer with is_end_i high
// closes the identifier and yields exactly one result.
// Output channel: out_valid_o / out_stall_i with port_offset_o and id_valid_o.
// port_offset_o is the FNV-1a hash mod 999 plus 1, or 0 with id_valid_o low
// when the id was empty, too long or held a disallowed character.
// Throughput: one input transfer per cycle while in_stall_o is low; the back
// end updates the hash for each character it pops. When nothing stalls, the
// result of a terminator passes through the queue, the s1 and s2 stages of the
// reciprocal-multiply modulo pipeline, then the output register.
// While out_stall_i is high the result holds and the pipeline fills; the
// queue then fills and in_stall_o rises only once it is full.
// Reset clears the queue, the pipeline and the hash state to the FNV offset
// basis; the block takes input in the first cycle after reset.
module id_hash_port_offset #(
  parameter int unsigned MAX_ID_LEN = ihpo_pkg::DEFAULT_MAX_ID_LEN,
  parameter int unsigned QUEUE_DEPTH = ihpo_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] id_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [9:0] port_offset_o,
  output logic       id_valid_o
);
  import ihpo_pkg::*;

  logic push, q_full, q_valid, q_pop, res_valid, res_ready;
  ihpo_item_t push_item, q_item;
  ihpo_res_t res;

  ihpo_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .id_byte_i  (id_byte_i),
    .is_end_i   (is_end_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_item_o(push_item)
  );

  ihpo_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_item)
  );

  ihpo_back #(
    .MAX_ID_LEN(MAX_ID_LEN)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  ihpo_mod u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_i        (res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .port_offset_o(port_offset_o),
    .id_valid_o   (id_valid_o)
  );

endmodule

### hdl/ihpo_front.sv
// Front end: takes input transfers and tags each character as allowed or not.
module ihpo_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            id_byte_i,
  input  logic                  is_end_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output ihpo_pkg::ihpo_item_t  push_item_o
);
  import ihpo_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    push_item_o.id_byte = id_byte_i;
    push_item_o.is_end = is_end_i;
    push_item_o.bad = !is_end_i && !char_allowed(id_byte_i);
  end

endmodule

### hdl/ihpo_fifo.sv
// Short queue of classified items between front and back end.
module ihpo_fifo #(
  parameter int unsigned DEPTH = ihpo_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ihpo_pkg::ihpo_item_t  push_item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output ihpo_pkg::ihpo_item_t  head_o
);
  import ihpo_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ihpo_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic do_pop;

  assign full_o = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o = mem_q[rd_ptr_q];
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

### hdl/ihpo_back.sv
// Back end: running FNV-1a hash, length count and bad-character flag.
module ihpo_back #(
  parameter int unsigned MAX_ID_LEN = ihpo_pkg::DEFAULT_MAX_ID_LEN
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ihpo_pkg::ihpo_item_t  q_item_i,
  output logic                  q_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ihpo_pkg::ihpo_res_t   res_o
);
  import ihpo_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ID_LEN + 2);

  logic [31:0] hash_q, hash_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic bad_q, bad_d;
  logic [31:0] mixed;

  assign res_valid_o = q_valid_i && q_item_i.is_end;
  assign q_pop_o = q_valid_i && (!q_item_i.is_end || res_ready_i);
  assign mixed = hash_q ^ {24'd0, q_item_i.id_byte};

  always_comb begin
    res_o.hash = hash_q;
    res_o.ok = count_q != '0 && count_q <= CNT_W'(MAX_ID_LEN) && !bad_q;
  end

  always_comb begin
    hash_d = hash_q;
    count_d = count_q;
    bad_d = bad_q;
    if (q_pop_o) begin
      if (q_item_i.is_end) begin
        hash_d = FNV_BASIS;
        count_d = '0;
        bad_d = 1'b0;
      end else begin
        hash_d = 32'(mixed * FNV_PRIME);
        if (count_q < CNT_W'(MAX_ID_LEN + 1)) begin
          count_d = count_q + CNT_W'(1);
        end
        bad_d = bad_q || q_item_i.bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
      count_q <= '0;
      bad_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      count_q <= count_d;
      bad_q <= bad_d;
    end
  end

endmodule

### hdl/ihpo_mod.sv
// Result pipeline: hash mod 999 by reciprocal multiply, then the output register.
module ihpo_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  output logic                 res_ready_o,
  input  ihpo_pkg::ihpo_res_t  res_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [9:0]           port_offset_o,
  output logic                 id_valid_o
);
  import ihpo_pkg::*;

  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, out_ready;
  logic [QUOT_W-1:0] s1_quot_q;
  logic [31:0] s1_hash_q;
  logic s1_ok_q;
  logic [REM_W-1:0] s2_rem_q;
  logic s2_ok_q;
  logic [9:0] offset_q;
  logic ok_q;
  logic [64:0] prod;
  logic [31:0] qmul, diff;
  logic [REM_W-1:0] rem_fix;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_ready = !s2_valid_q || out_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign res_ready_o = s1_ready;

  assign prod = 65'(res_i.hash) * 65'(MOD_RECIP);
  assign qmul = 32'(32'(s1_quot_q) * 32'(PORT_MOD));
  assign diff = s1_hash_q - qmul;
  assign rem_fix = (s2_rem_q >= REM_W'(PORT_MOD)) ? s2_rem_q - REM_W'(PORT_MOD) : s2_rem_q;

  assign out_valid_o = out_valid_q;
  assign port_offset_o = offset_q;
  assign id_valid_o = ok_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready && res_valid_i) begin
      s1_quot_q <= prod[MOD_SHIFT +: QUOT_W];
      s1_hash_q <= res_i.hash;
      s1_ok_q <= res_i.ok;
    end
    if (s2_ready && s1_valid_q) begin
      s2_rem_q <= diff[REM_W-1:0];
      s2_ok_q <= s1_ok_q;
    end
    if (out_ready && s2_valid_q) begin
      offset_q <= s2_ok_q ? 10'(rem_fix) + 10'd1 : 10'd0;
      ok_q <= s2_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= res_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

endmodule

### hdl/ihpo_checker.sv
// Port-level checks for the identifier hash port offset block, bound to the top.
module ihpo_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] id_byte_i,
  input logic       is_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [9:0] port_offset_o,
  input logic       id_valid_o
);
  import ihpo_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(id_byte_i) && $stable(is_end_i))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(port_offset_o) &&
    $stable(id_valid_o))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !id_valid_o |-> port_offset_o == 10'd0)
    else $error("invalid id with nonzero offset");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && id_valid_o |-> port_offset_o != 10'd0 && port_offset_o <= PORT_MOD)
    else $error("offset out of range");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) || !$past(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("result or stall right after reset");

endmodule

bind id_hash_port_offset ihpo_checker u_ihpo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .id_byte_i    (id_byte_i),
  .is_end_i     (is_end_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .port_offset_o(port_offset_o),
  .id_valid_o   (id_valid_o)
);
